/* hdl/bresenham_line_stepper_defines.svh */
// ----------------------------------------------------------------------------
// Bresenham line stepper assertion macros
// Shared concurrent check forms for the stepper modules.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_STEPPER_DEFINES_SVH
`define BRESENHAM_LINE_STEPPER_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent.
`define BLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line stepper check failed");

// Check a consequence in the cycle after its antecedent.
`define BLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line stepper check failed");

`endif

/* hdl/bls_pkg.sv */
// ----------------------------------------------------------------------------
// bls_pkg
// Types and constants shared by the Bresenham line stepper modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bls_pkg;

    localparam int COORD_BITS   = 12;
    localparam int ERR_BITS     = COORD_BITS + 2;
    localparam int CANVAS_BITS  = 11;
    localparam int CFG_IDX_BITS = 1;
    localparam int CMP_BITS     = ((COORD_BITS > CANVAS_BITS) ? COORD_BITS : CANVAS_BITS) + 1;

    localparam logic [CANVAS_BITS-1:0] CANVAS_W_RESET = CANVAS_BITS'(640);
    localparam logic [CANVAS_BITS-1:0] CANVAS_H_RESET = CANVAS_BITS'(480);
    localparam logic signed [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CANVAS_WIDTH  = 1'b0,
        REG_CANVAS_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        REQ_START   = 1'b0,
        REQ_ADVANCE = 1'b1
    } t_req_kind;

    typedef struct packed {
        logic                         req_type;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } t_req;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic                         inside_res;
        logic                         last;
    } t_res;

    typedef struct packed {
        logic                         is_start;
        logic signed [COORD_BITS-1:0] x0;
        logic signed [COORD_BITS-1:0] y0;
        logic signed [COORD_BITS-1:0] x1;
        logic signed [COORD_BITS-1:0] y1;
        logic        [COORD_BITS-1:0] adx;
        logic        [COORD_BITS-1:0] ady;
        logic                         sxn;
        logic                         syn;
    } t_cmd;

    typedef struct packed {
        logic [CANVAS_BITS-1:0] width;
        logic [CANVAS_BITS-1:0] height;
    } t_canvas;

endpackage

/* hdl/bresenham_line_stepper.sv */
// ----------------------------------------------------------------------------
// bresenham_line_stepper
// Integer Bresenham line engine for all octants with canvas clipping flags.
// ----------------------------------------------------------------------------
// Request channel: write a word on i_req with push while full is low. A start
// word (req_type 0) loads both endpoints and gives no result; an advance word
// (req_type 1) gives one pixel while a line is active, none when idle.
// Result channel: while empty is low, o_res holds the oldest pixel with its
// inside and last flags; pop takes it. After the pixel flagged last the engine
// goes idle until the next start word.
// Configuration: cfg_valid with i_cfg_index and i_cfg_data writes canvas width
// (index 0) or height (index 1); cfg_ready is always high. Write only while idle.
// Path: each advance word passes through the command queue, and its pixel is
// registered into the output word when the engine takes the word from the queue.
// Throughput: one word per cycle in, one pixel per cycle out while pop keeps up.
// Stall: if pop stays low, the output word holds, the two-entry command queue
// fills and full rises; nothing is dropped.
// Reset: queue and output register empty, engine idle, canvas 640 by 480.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bresenham_line_stepper import bls_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    input  t_req                    i_req,
    output logic                    full,
    output logic                    empty,
    output t_res                    o_res,
    input  logic                    pop,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CANVAS_BITS-1:0]  i_cfg_data
);

    t_canvas r_canvas;
    logic    cmd_valid;
    logic    cmd_take;
    t_cmd    cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas.width  <= CANVAS_W_RESET;
            r_canvas.height <= CANVAS_H_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_CANVAS_WIDTH:  r_canvas.width  <= i_cfg_data;
                REG_CANVAS_HEIGHT: r_canvas.height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    bls_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_req       (i_req),
        .o_full      (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    bls_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_canvas    (r_canvas),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_empty     (empty),
        .o_res       (o_res),
        .i_pop       (pop)
    );

endmodule

/* hdl/bls_front.sv */
// ----------------------------------------------------------------------------
// bls_front
// Accepts request words, sets up deltas and step signs for start requests,
// and queues classified commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bresenham_line_stepper_defines.svh"

module bls_front import bls_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_req,
    output logic o_full,
    output logic o_cmd_valid,
    output t_cmd o_cmd,
    input  logic i_cmd_take
);

    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    t_cmd       r_mem [2];

    logic                       push_en;
    logic                       pop_en;
    t_cmd                       cmd_new;
    logic signed [COORD_BITS:0] dx_full;
    logic signed [COORD_BITS:0] dy_full;
    logic signed [COORD_BITS:0] dx_neg;
    logic signed [COORD_BITS:0] dy_neg;

    assign o_full      = (r_count == 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_mem[r_rd_ptr];
    assign push_en     = i_push && !o_full;
    assign pop_en      = i_cmd_take && o_cmd_valid;

    always_comb begin
        dx_full = {i_req.end_x[COORD_BITS-1], i_req.end_x}
                - {i_req.start_x[COORD_BITS-1], i_req.start_x};
        dy_full = {i_req.end_y[COORD_BITS-1], i_req.end_y}
                - {i_req.start_y[COORD_BITS-1], i_req.start_y};
        dx_neg  = -dx_full;
        dy_neg  = -dy_full;
        cmd_new.is_start = (i_req.req_type == REQ_START);
        cmd_new.x0  = i_req.start_x;
        cmd_new.y0  = i_req.start_y;
        cmd_new.x1  = i_req.end_x;
        cmd_new.y1  = i_req.end_y;
        cmd_new.adx = dx_full[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx_full[COORD_BITS-1:0];
        cmd_new.ady = dy_full[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy_full[COORD_BITS-1:0];
        cmd_new.sxn = dx_full[COORD_BITS] || (dx_full == '0);
        cmd_new.syn = dy_full[COORD_BITS] || (dy_full == '0);
    end

    always_comb begin
        n_count = r_count;
        if (push_en && !pop_en) begin
            n_count = r_count + 2'd1;
        end else if (pop_en && !push_en) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_count <= n_count;
            if (push_en) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop_en) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_mem[r_wr_ptr] <= cmd_new;
        end
    end

    `BLS_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= 2'd2)
    `BLS_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, i_cmd_take, o_cmd_valid || !pop_en)
    `BLS_ASSERT_NEXT(a_fill_count, i_clk, i_rst_n, push_en && !pop_en, r_count == $past(r_count) + 2'd1)

endmodule

/* hdl/bls_back.sv */
// ----------------------------------------------------------------------------
// bls_back
// Bresenham stepping engine: loads lines from start commands, emits one
// pixel per advance command while a line is active into a one-word output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bresenham_line_stepper_defines.svh"

module bls_back import bls_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_canvas i_canvas,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_take,
    output logic    o_empty,
    output t_res    o_res,
    input  logic    i_pop
);

    logic                         r_busy;
    logic                         r_out_valid;
    t_res                         r_res;
    logic signed [COORD_BITS-1:0] r_cur_x;
    logic signed [COORD_BITS-1:0] r_cur_y;
    logic signed [COORD_BITS-1:0] r_tgt_x;
    logic signed [COORD_BITS-1:0] r_tgt_y;
    logic        [COORD_BITS-1:0] r_adx;
    logic        [COORD_BITS-1:0] r_ady;
    logic                         r_sxn;
    logic                         r_syn;
    logic signed [ERR_BITS-1:0]   r_err;

    logic                         out_free;
    logic                         out_load;
    logic                         start_load;
    logic                         is_last;
    logic                         in_canvas;
    logic                         step_x;
    logic                         step_y;
    logic signed [ERR_BITS:0]     e2;
    logic signed [ERR_BITS:0]     adx_w;
    logic signed [ERR_BITS:0]     ady_w;
    logic signed [ERR_BITS-1:0]   adx_e;
    logic signed [ERR_BITS-1:0]   ady_e;
    logic signed [ERR_BITS-1:0]   cmd_adx_e;
    logic signed [ERR_BITS-1:0]   cmd_ady_e;
    logic signed [ERR_BITS-1:0]   n_err;
    logic signed [COORD_BITS-1:0] n_cur_x;
    logic signed [COORD_BITS-1:0] n_cur_y;

    assign out_free   = !r_out_valid || i_pop;
    assign o_cmd_take = i_cmd_valid && (i_cmd.is_start || !r_busy || out_free);
    assign start_load = o_cmd_take && i_cmd.is_start;
    assign out_load   = o_cmd_take && !i_cmd.is_start && r_busy;
    assign o_empty    = !r_out_valid;
    assign o_res      = r_res;

    always_comb begin
        is_last   = (r_cur_x == r_tgt_x) && (r_cur_y == r_tgt_y);
        in_canvas = !r_cur_x[COORD_BITS-1] && !r_cur_y[COORD_BITS-1]
                 && (CMP_BITS'($unsigned(r_cur_x)) < CMP_BITS'(i_canvas.width))
                 && (CMP_BITS'($unsigned(r_cur_y)) < CMP_BITS'(i_canvas.height));

        adx_e     = $signed({{(ERR_BITS-COORD_BITS){1'b0}}, r_adx});
        ady_e     = $signed({{(ERR_BITS-COORD_BITS){1'b0}}, r_ady});
        cmd_adx_e = $signed({{(ERR_BITS-COORD_BITS){1'b0}}, i_cmd.adx});
        cmd_ady_e = $signed({{(ERR_BITS-COORD_BITS){1'b0}}, i_cmd.ady});
        adx_w     = {1'b0, adx_e};
        ady_w     = {1'b0, ady_e};
        e2        = {r_err, 1'b0};
        step_x    = (e2 > -ady_w);
        step_y    = (e2 < adx_w);

        n_err   = r_err - (step_x ? ady_e : '0) + (step_y ? adx_e : '0);
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        if (step_x) begin
            n_cur_x = r_sxn ? r_cur_x - COORD_ONE : r_cur_x + COORD_ONE;
        end
        if (step_y) begin
            n_cur_y = r_syn ? r_cur_y - COORD_ONE : r_cur_y + COORD_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_tgt_x     <= '0;
            r_tgt_y     <= '0;
            r_adx       <= '0;
            r_ady       <= '0;
            r_sxn       <= 1'b0;
            r_syn       <= 1'b0;
            r_err       <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (start_load) begin
                r_busy  <= 1'b1;
                r_cur_x <= i_cmd.x0;
                r_cur_y <= i_cmd.y0;
                r_tgt_x <= i_cmd.x1;
                r_tgt_y <= i_cmd.y1;
                r_adx   <= i_cmd.adx;
                r_ady   <= i_cmd.ady;
                r_sxn   <= i_cmd.sxn;
                r_syn   <= i_cmd.syn;
                r_err   <= cmd_adx_e - cmd_ady_e;
            end else if (out_load) begin
                if (is_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cur_x <= n_cur_x;
                    r_cur_y <= n_cur_y;
                    r_err   <= n_err;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_res.pixel_x    <= r_cur_x;
            r_res.pixel_y    <= r_cur_y;
            r_res.inside_res <= in_canvas;
            r_res.last       <= is_last;
        end
    end

    `BLS_ASSERT_NOW(a_emit_when_busy, i_clk, i_rst_n, out_load, r_busy && !i_cmd.is_start)
    `BLS_ASSERT_NEXT(a_last_goes_idle, i_clk, i_rst_n, out_load && is_last, !r_busy && r_res.last)
    `BLS_ASSERT_NEXT(a_start_goes_busy, i_clk, i_rst_n, start_load, r_busy && !$past(out_load))

endmodule
